[rtl/mexp_pkg.sv]
// Shared widths, constants and types for the modular exponentiation block.
// No dependencies; every other file imports this package.
package mexp_pkg;

  localparam int MOD_W       = 31;                 // modulus and result width
  localparam int BASE_W      = 63;                 // base field width
  localparam int EXP_FIELD_W = 63;                 // exponent field width
  localparam int EXP_BITS    = 63;                 // low exponent bits processed
  localparam int OPER_W      = BASE_W;             // multiplier operand register
  localparam int PAD_W       = OPER_W - MOD_W;     // left-align a residue in OPER_W
  localparam int CNT_W       = $clog2(OPER_W + 1);

  typedef logic [MOD_W-1:0]       mod_t;
  typedef logic [BASE_W-1:0]      base_t;
  typedef logic [EXP_FIELD_W-1:0] exp_field_t;
  typedef logic [EXP_BITS-1:0]    exp_t;
  typedef logic [OPER_W-1:0]      oper_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  localparam mod_t MOD_RESET = MOD_W'(1000000007);
  localparam mod_t MOD_ONE   = MOD_W'(1);
  localparam mod_t MOD_TWO   = MOD_W'(2);

  // Command to the shared modular multiply unit.
  typedef struct packed {
    logic start;
    mod_t a;        // multiplicand, must be below the modulus
    oper_t b;       // multiplier bits, scanned from the MSB down
    cnt_t nbits;    // number of multiplier bits to scan
  } mm_cmd_t;

  // Status back from the multiply unit.
  typedef struct packed {
    logic done;     // one-cycle pulse, product valid
    mod_t product;
  } mm_stat_t;

endpackage

[rtl/mexp_if.sv]
// Valid/ready channel interfaces for input items and results.
// Depends on mexp_pkg.
interface mexp_in_if;
  import mexp_pkg::*;
  logic       valid;
  logic       ready;
  base_t      base_value;
  exp_field_t exponent;
  modport source (output valid, output base_value, output exponent, input ready);
  modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

interface mexp_out_if;
  import mexp_pkg::*;
  logic valid;
  logic ready;
  mod_t result;
  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

[rtl/modular_exponentiation.sv]
// Modular exponentiation, base ** exponent mod modulus, right-to-left binary.
// The base is first reduced mod m, then each modular multiply or squaring runs
// on the shared unit, one bit per cycle. One item at a time: a new item is
// taken once the last result has moved to the output register. A modulus
// below two needs no multiply; a zero exponent stops after the base reduction.
// Reset (rst, synchronous): idle, no result held, modulus = 1000000007.
module modular_exponentiation (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  mexp_pkg::mod_t cfg_wr_data,
  mexp_in_if.sink        in_ch,
  mexp_out_if.source     out_ch
);
  import mexp_pkg::*;

  mod_t     modulus;
  mm_cmd_t  mm_cmd;
  mm_stat_t mm_stat;
  logic     res_valid;
  mod_t     res;
  logic     res_take;
  logic     out_valid;
  mod_t     out_res;

  // Modulus register; the user must write it only while the block is idle. The block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_RESET;
    end else if (cfg_wr_en) begin
      modulus <= cfg_wr_data;
    end
  end

  // Sequencer: owns the input channel, the exponent shift register and the
  // acc / cur residues, and drives the shared multiply unit.
  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .modulus   (modulus),
    .cmd       (mm_cmd),
    .stat      (mm_stat),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // Shared bit-serial modular multiplier: used for the base reduction (all
  // 63 base bits) and every multiply and squaring (31 multiplier bits each).
  mexp_modmul u_modmul (
    .clk     (clk),
    .rst     (rst),
    .modulus (modulus),
    .cmd     (mm_cmd),
    .stat    (mm_stat)
  );

  // Output register: a finished result moves here so the sequencer can go
  // back to idle and take the next transfer while this one waits downstream.
  assign res_take = res_valid && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign out_ch.valid  = out_valid;
  assign out_ch.result = out_res;

endmodule

[rtl/mexp_modmul.sv]
// Shared bit-serial modular multiply unit: product = a * b mod m.
// One multiplier bit per cycle, MSB first. Depends on mexp_pkg.
module mexp_modmul (
  input  logic               clk,
  input  logic               rst,
  input  mexp_pkg::mod_t     modulus,
  input  mexp_pkg::mm_cmd_t  cmd,
  output mexp_pkg::mm_stat_t stat
);
  import mexp_pkg::*;

  mod_t  acc;
  mod_t  acc_next;
  mod_t  a_r;
  oper_t b_r;
  cnt_t  cnt;
  logic  busy;
  logic  done;

  logic [MOD_W+1:0] t;
  logic [MOD_W+1:0] m1;
  logic [MOD_W+1:0] m2;

  // acc < m and a < m, so 2*acc + a < 3m: at most one of m or 2m comes off.
  always_comb begin
    m1 = {2'b00, modulus};
    m2 = {1'b0, modulus, 1'b0};
    t  = {1'b0, acc, 1'b0} + {2'b00, (b_r[OPER_W-1] ? a_r : MOD_W'(0))};
    if (t >= m2) begin
      acc_next = MOD_W'(t - m2);
    end else if (t >= m1) begin
      acc_next = MOD_W'(t - m1);
    end else begin
      acc_next = MOD_W'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        acc  <= '0;
        a_r  <= cmd.a;
        b_r  <= cmd.b;
        cnt  <= cmd.nbits;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc_next;
        b_r <= b_r << 1;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.done    = done;
  assign stat.product = acc;

endmodule

[rtl/mexp_ctrl.sv]
// Square-and-multiply sequencer: reduces the base, then walks the exponent
// bits, issuing multiplies and squarings to mexp_modmul. Depends on mexp_pkg.
module mexp_ctrl (
  input  logic               clk,
  input  logic               rst,
  mexp_in_if.sink            in_ch,
  input  mexp_pkg::mod_t     modulus,
  output mexp_pkg::mm_cmd_t  cmd,
  input  mexp_pkg::mm_stat_t stat,
  output logic               res_valid,
  output mexp_pkg::mod_t     res,
  input  logic               res_take
);
  import mexp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,   // base reduction running
    S_MUL,   // acc * cur running
    S_SQR,   // cur * cur running
    S_FIN    // result waiting for the output register
  } state_t;

  state_t state;
  exp_t   exp_r;
  exp_t   exp_shift;
  mod_t   acc;
  mod_t   cur;

  assign exp_shift   = exp_r >> 1;
  assign in_ch.ready = (state == S_IDLE);
  assign res_valid   = (state == S_FIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cmd.start <= 1'b0;
    end else begin
      cmd.start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            exp_r <= in_ch.exponent[EXP_BITS-1:0];
            acc   <= MOD_ONE;
            if (modulus < MOD_TWO) begin
              res   <= '0;
              state <= S_FIN;
            end else begin
              // base mod m: scan the base into 1 * base
              cmd.start <= 1'b1;
              cmd.a     <= MOD_ONE;
              cmd.b     <= OPER_W'(in_ch.base_value);
              cmd.nbits <= CNT_W'(BASE_W);
              state     <= S_RED;
            end
          end
        end
        S_RED: begin
          if (stat.done) begin
            cur <= stat.product;
            if (exp_r == '0) begin
              res   <= MOD_ONE;
              state <= S_FIN;
            end else if (exp_r[0]) begin
              cmd.start <= 1'b1;
              cmd.a     <= stat.product;
              cmd.b     <= {acc, {PAD_W{1'b0}}};
              cmd.nbits <= CNT_W'(MOD_W);
              state     <= S_MUL;
            end else begin
              cmd.start <= 1'b1;
              cmd.a     <= stat.product;
              cmd.b     <= {stat.product, {PAD_W{1'b0}}};
              cmd.nbits <= CNT_W'(MOD_W);
              state     <= S_SQR;
            end
          end
        end
        S_MUL: begin
          if (stat.done) begin
            acc <= stat.product;
            if (exp_shift == '0) begin
              // last set bit: the final squaring is not needed
              res   <= stat.product;
              state <= S_FIN;
            end else begin
              cmd.start <= 1'b1;
              cmd.a     <= cur;
              cmd.b     <= {cur, {PAD_W{1'b0}}};
              cmd.nbits <= CNT_W'(MOD_W);
              state     <= S_SQR;
            end
          end
        end
        S_SQR: begin
          if (stat.done) begin
            cur   <= stat.product;
            exp_r <= exp_shift;
            // squaring only runs while higher bits remain set
            if (exp_shift[0]) begin
              cmd.start <= 1'b1;
              cmd.a     <= stat.product;
              cmd.b     <= {acc, {PAD_W{1'b0}}};
              cmd.nbits <= CNT_W'(MOD_W);
              state     <= S_MUL;
            end else begin
              cmd.start <= 1'b1;
              cmd.a     <= stat.product;
              cmd.b     <= {stat.product, {PAD_W{1'b0}}};
              cmd.nbits <= CNT_W'(MOD_W);
              state     <= S_SQR;
            end
          end
        end
        S_FIN: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[bench/mexp_result_checker.sv]
`timescale 1ns / 1ps
// Result checker for modular_exponentiation: watches the item, result and config ports.
// Predicts each result on input transfer and compares in order. Depends on mexp_pkg.
module mexp_result_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  mexp_pkg::mod_t       cfg_wr_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  mexp_pkg::base_t      in_base,
  input  mexp_pkg::exp_field_t in_exponent,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  mexp_pkg::mod_t       out_result,
  output int                   pending,
  output int                   fail_count
);
  import mexp_pkg::*;

  mod_t modulus_q;
  mod_t expected_results[$];
  int   mismatch_count = 0;
  int   result_idx     = 0;

  assign fail_count = mismatch_count;

  // Right-to-left square-and-multiply on 64-bit words; residues stay below 2^31.
  function automatic mod_t power_mod(base_t b, exp_field_t e, mod_t m);
    longint unsigned acc;
    longint unsigned cur;
    longint unsigned mm;
    exp_t            ebits;
    if (m < MOD_TWO) begin
      return '0;
    end
    mm    = {33'd0, m};
    cur   = {1'b0, b} % mm;
    acc   = 1;
    ebits = e[EXP_BITS-1:0];
    for (int i = 0; i < EXP_BITS; i++) begin
      if (ebits[i]) begin
        acc = (acc * cur) % mm;
      end
      cur = (cur * cur) % mm;
    end
    return mod_t'(acc % mm);
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      modulus_q = MOD_RESET;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(power_mod(in_base, in_exponent, modulus_q));
      end
      if (cfg_wr_en) begin
        modulus_q = cfg_wr_data;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch($sformatf("result %0d with no item outstanding", out_result));
        end else begin
          if (out_result !== expected_results[0]) begin
            flag_mismatch($sformatf("result #%0d is %0d, predicted %0d",
                                    result_idx, out_result, expected_results[0]));
          end
          void'(expected_results.pop_front());
        end
        result_idx++;
      end
    end
    pending = expected_results.size();
  end

endmodule

[bench/tb_modular_exponentiation.sv]
`timescale 1ns / 1ps
// Top of the modular_exponentiation bench: clock, reset, item stimulus, result stalls.
// Depends on mexp_pkg, mexp_if, modular_exponentiation and mexp_result_checker.
module tb_modular_exponentiation;
  import mexp_pkg::*;

  localparam int          RESET_CYCLES = 11;
  localparam int          NUM_PHASES   = 10;
  localparam int          IDLE_GAP     = 8;       // quiet cycles before a config write
  localparam int          DRAIN_CYCLES = 300;     // watch for stray results at the end
  localparam int          HOLD_CYCLES  = 3000;    // long receiver hold-off
  // Slowest correct run: ~650 items, each with a full 63-bit exponent, plus gaps and stalls, x4.
  localparam longint      RUN_LIMIT    = 12_000_000;
  localparam mod_t        MOD_TOP      = {MOD_W{1'b1}};
  localparam base_t       BASE_ALL     = '1;
  localparam exp_field_t  EXP_ALL      = '1;

  // Receiver stall patterns, picked at random for stretches of cycles.
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  mod_t cfg_wr_data;
  int   pending;
  int   fail_count;

  longint unsigned cycle_cnt = 0;

  mexp_in_if  in_ch ();
  mexp_out_if out_ch ();

  modular_exponentiation i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  mexp_result_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_base     (in_ch.base_value),
    .in_exponent (in_ch.exponent),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_result  (out_ch.result),
    .pending     (pending),
    .fail_count  (fail_count)
  );

  // 12 ns clock, first rising edge at 6 ns.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Watchdog: a hung block or a lost result ends up here.
  initial begin
    wait (cycle_cnt >= RUN_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side. Stall pattern is re-picked at random whenever its stretch
  // runs out; a hold-off request from the stimulus side parks ready low for a
  // long hold-off so the result backs up and the block stops taking items
  // while the sender keeps offering.
  // ---------------------------------------------------------------------------
  rx_mode_t    rx_mode      = RX_OPEN;
  int unsigned rx_mode_left = 0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_tick      = 0;
  int          hold_req     = 0;
  int          hold_served  = 0;

  always @(posedge clk) begin
    rx_tick++;
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_req != hold_served) begin
      hold_served  = hold_req;
      rx_hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 400);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_OPEN:     out_ch.ready <= 1'b1;
        RX_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE:   out_ch.ready <= ($urandom_range(0, 3) == 0);
        RX_PERIODIC: out_ch.ready <= ((rx_tick % 5) != 0);
        default:     out_ch.ready <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side: bursts of 1..10 items, gaps between bursts (mostly short,
  // sometimes long enough to land in the middle of a computation).
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;

  // Offer one item and return at the edge where it transfers. valid stays
  // high into the next item unless a gap starts.
  task automatic push_item(input base_t b, input exp_field_t e);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300) : $urandom_range(0, 20);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.base_value <= b;
    in_ch.exponent   <= e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  // Config is only touched once every result is back and the block is quiet.
  task automatic set_modulus(input mod_t m);
    @(posedge clk);
    wait (pending == 0);
    repeat (IDLE_GAP) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Bases: half full-width random, the other half small values, multiples of the
  // modulus, modulus - 1, all ones and shortened values.
  function automatic base_t pick_base(input mod_t m);
    int unsigned sel;
    base_t       v;
    sel = $urandom_range(0, 9);
    v   = base_t'({$urandom, $urandom});
    case (sel)
      0:       v = base_t'($urandom_range(0, 3));
      1:       v = base_t'(m) * base_t'($urandom_range(0, 1000));
      2:       v = base_t'(m) - base_t'(1);
      3:       v = BASE_ALL;
      4:       v = v >> $urandom_range(0, 62);
      default: ;
    endcase
    return v;
  endfunction

  // Exponents: most are short so the run stays fast; a few span the full
  // field or carry a lone high bit to walk the long squaring chain.
  function automatic exp_field_t pick_exponent();
    int unsigned sel;
    int unsigned w;
    exp_field_t  raw;
    sel = $urandom_range(0, 99);
    raw = exp_field_t'({$urandom, $urandom});
    if (sel < 5) begin
      return raw;
    end else if (sel < 8) begin
      return exp_field_t'(1) << $urandom_range(13, EXP_FIELD_W - 1);
    end else if (sel < 15) begin
      return exp_field_t'($urandom_range(0, 2));
    end
    w = $urandom_range(1, 12);
    return raw & ((exp_field_t'(1) << w) - exp_field_t'(1));
  endfunction

  // Modulus per phase: both extremes, the below-two values, a power of two,
  // the reset value again and a few random ones.
  function automatic mod_t phase_modulus(input int p);
    case (p)
      0:       return MOD_TOP;
      1:       return MOD_TWO;
      2:       return '0;
      3:       return MOD_ONE;
      4:       return mod_t'(3);
      5:       return mod_t'($urandom_range(2, 32'h7FFF_FFFF));
      6:       return mod_t'($urandom_range(2, 1000));
      7:       return mod_t'(65536);
      8:       return MOD_RESET;
      default: return mod_t'($urandom);
    endcase
  endfunction

  // Directed items under the reset modulus (a prime).
  task automatic run_directed();
    push_item('0, '0);                                   // zero to the zero
    push_item('0, exp_field_t'(5));
    push_item(base_t'(1), EXP_ALL);
    push_item(BASE_ALL, '0);
    push_item(BASE_ALL, exp_field_t'(1));
    push_item(BASE_ALL, EXP_ALL);
    push_item(base_t'(2), exp_field_t'(MOD_RESET) - exp_field_t'(1));   // Fermat: gives 1
    push_item(base_t'(MOD_RESET), exp_field_t'(3));      // base reduces to zero
    push_item(base_t'(MOD_RESET) - base_t'(1), exp_field_t'(2));
    push_item(base_t'(12345), exp_field_t'(1) << (EXP_FIELD_W - 1));
    push_item(base_t'(1) << (BASE_W - 1), exp_field_t'(7));
    push_item(base_t'(3), exp_field_t'({(EXP_FIELD_W + 1) / 2{2'b01}}));
    push_item(base_t'({(BASE_W + 1) / 2{2'b10}}),
              exp_field_t'({(EXP_FIELD_W + 1) / 2{2'b10}}));
    push_item(base_t'(MOD_RESET) * base_t'(2) + base_t'(5), exp_field_t'(1));
    in_ch.valid <= 1'b0;
  endtask

  task automatic run_random(input int p, input mod_t m, input int count);
    for (int k = 0; k < count; k++) begin
      // two long receiver hold-offs, one with a normal modulus, one later on
      if ((p == 0 || p == 5) && k == 3) begin
        hold_req++;
      end
      push_item(pick_base(m), pick_exponent());
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    mod_t m;
    int   n;
    in_ch.valid      <= 1'b0;
    in_ch.base_value <= '0;
    in_ch.exponent   <= '0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    rst              <= 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    // below-two moduli finish fast and only ever give zero: fewer items there
    for (int p = 0; p < NUM_PHASES; p++) begin
      m = phase_modulus(p);
      n = (p == 2 || p == 3) ? 20 : 76;
      set_modulus(m);
      run_random(p, m, n);
    end

    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
